FILE: sv/svri_pkg.sv
// Shared constants, types and state codes for the seam vertex remap indexer.
package svri_pkg;

    // Field widths of the corner and result beats.
    localparam int VIDX_W   = 10;
    localparam int S_IN_W   = 11;
    localparam int T_W      = 12;
    localparam int OIDX_W   = 11;
    localparam int S_OUT_W  = 12;
    localparam int CNT_W    = 12;
    localparam int SKIN_W   = 13;

    // Default number of source vertices per mesh.
    localparam int MAX_VERTS_DEF = 1024;

    // Configuration port geometry.
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // Register index, taken from the word address bit of paddr.
    localparam logic REG_SKIN_WIDTH = 1'b0;

    // Mesh epoch mark kept beside each slot entry.
    localparam int EPOCH_W = 6;
    localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
    localparam logic [EPOCH_W-1:0] EPOCH_LAST  = '1;

    // Saturation limit of the adjusted s coordinate.
    localparam logic [S_OUT_W-1:0] S_MAX = '1;

    // Control states.
    typedef enum logic {
        ST_RUN,
        ST_CLEAR
    } t_state;

    // One entry of the slot memory.
    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [OIDX_W-1:0]  idx;
    } t_slot;

    // A corner held between the memory read and the write back.
    typedef struct packed {
        logic              new_mesh;
        logic              in_range;
        logic              back;
        logic [VIDX_W-1:0] vidx;
        logic [S_IN_W-1:0] s;
        logic [T_W-1:0]    t;
    } t_corner;

endpackage

FILE: sv/svri_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
module svri_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read; a read of the entry being written returns the old data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/seam_vertex_remap_indexer.sv
// Top level of the seam vertex remap indexer: slot lookup, vertex numbering and register port.
//
// Each corner beat accepted on start/busy yields exactly one result beat, strobed on
// o_result_valid through the r_s1 and r_out registers; the receiver cannot stall, so results
// are simply presented for one cycle. Corners stream at one per cycle while busy is low: the
// slot memory is read when a corner is accepted and written back the next cycle, and a write
// that collides with the following read is forwarded. Slots carry a 6-bit mesh epoch mark, so
// a new-mesh corner costs nothing except on every 63rd mesh, when the mark wraps: then busy is
// raised while the wrapping corner is in the second stage and stays high for a clearing pass
// over every entry of the slot memory. The same clearing pass runs after reset, during which
// no corner is taken; register writes are accepted at any time.
module seam_vertex_remap_indexer #(
    parameter int MAX_VERTS = svri_pkg::MAX_VERTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Corner channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_new_mesh,
    input  logic [svri_pkg::VIDX_W-1:0]   i_vertex_index,
    input  logic                          i_faces_front,
    input  logic                          i_on_seam,
    input  logic [svri_pkg::S_IN_W-1:0]   i_tex_s,
    input  logic [svri_pkg::T_W-1:0]      i_tex_t,
    // Result channel
    output logic                          o_result_valid,
    output logic [svri_pkg::OIDX_W-1:0]   o_out_index,
    output logic                          o_is_new_vertex,
    output logic [svri_pkg::VIDX_W-1:0]   o_new_source_index,
    output logic [svri_pkg::S_OUT_W-1:0]  o_new_s,
    output logic [svri_pkg::T_W-1:0]      o_new_t,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [svri_pkg::APB_AW-1:0]   paddr,
    input  logic [svri_pkg::APB_DW-1:0]   pwdata,
    output logic [svri_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import svri_pkg::*;

    localparam int SLOTS = 2 * MAX_VERTS;
    localparam int AW    = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);

    // Control and payload registers.
    t_state               r_state;
    t_state               n_state;
    logic [SKIN_W-1:0]    r_skin;
    logic [EPOCH_W-1:0]   r_epoch;
    logic [CNT_W-1:0]     r_count;
    logic [AW-1:0]        r_clr_addr;

    logic                 r_s1_valid;
    t_corner              r_s1;
    logic [AW-1:0]        r_s1_addr;

    logic                 r_fw_valid;
    logic [AW-1:0]        r_fw_addr;
    t_slot                r_fw_data;

    logic                 r_pend_valid;
    logic [AW-1:0]        r_pend_addr;
    t_slot                r_pend_data;

    logic                 r_out_valid;
    logic [OIDX_W-1:0]    r_out_index;
    logic                 r_out_new;
    logic [VIDX_W-1:0]    r_out_src;
    logic [S_OUT_W-1:0]   r_out_s;
    logic [T_W-1:0]       r_out_t;

    // Combinational signals.
    logic                 accept;
    logic                 in_range_in;
    logic                 back_in;
    logic [AW-1:0]        slot_in;
    t_slot                ram_rdata;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    t_slot                ram_wdata;
    t_slot                rd;
    logic                 wrap;
    logic [EPOCH_W-1:0]   epoch_eff;
    logic [CNT_W-1:0]     cnt_base;
    logic                 hit;
    logic                 make_new;
    logic [SKIN_W-1:0]    s_sum;
    logic [S_OUT_W-1:0]   new_s;
    t_slot                new_slot;
    logic                 clr_last;
    logic                 reg_idx;
    logic                 cfg_wr;

    // Corner acceptance and slot address.
    assign accept      = start && !busy;
    assign in_range_in = {{(32 - VIDX_W){1'b0}}, i_vertex_index} < 32'(MAX_VERTS);
    assign back_in     = !i_faces_front && i_on_seam;
    assign slot_in     = AW'({i_vertex_index, back_in});

    // Slot memory: epoch mark and output index of every remap slot.
    svri_ram #(
        .WIDTH ($bits(t_slot)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (slot_in),
        .o_rdata (ram_rdata)
    );

    // Second stage: decide whether the slot is already emitted in this mesh.
    always_comb begin
        wrap      = r_s1.new_mesh && (r_epoch == EPOCH_LAST);
        if (!r_s1.new_mesh) begin
            epoch_eff = r_epoch;
        end else if (wrap) begin
            epoch_eff = EPOCH_FIRST;
        end else begin
            epoch_eff = r_epoch + EPOCH_W'(1);
        end
        cnt_base  = r_s1.new_mesh ? '0 : r_count;
        rd        = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : ram_rdata;
        hit       = !r_s1.new_mesh && (rd.epoch == r_epoch);
        make_new  = r_s1_valid && r_s1.in_range && !hit;
        new_slot.epoch = epoch_eff;
        new_slot.idx   = cnt_base[OIDX_W-1:0];
    end

    // Seam shift of s by half the skin width for back-facing seam corners, saturating.
    always_comb begin
        s_sum = {2'b00, r_s1.s} + {1'b0, r_skin[SKIN_W-1:1]};
        if (!r_s1.back) begin
            new_s = {1'b0, r_s1.s};
        end else if (s_sum[SKIN_W-1]) begin
            new_s = S_MAX;
        end else begin
            new_s = s_sum[S_OUT_W-1:0];
        end
    end

    assign clr_last = (r_clr_addr == LAST_SLOT);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_RUN: begin
                if (r_s1_valid && wrap) begin
                    n_state = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (clr_last) begin
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
    end

    // State outputs: busy and the memory write port.
    always_comb begin
        busy      = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_s1_addr;
        ram_wdata = new_slot;
        unique case (r_state)
            ST_RUN: begin
                busy   = r_s1_valid && wrap;
                ram_we = make_new && !wrap;
            end
            ST_CLEAR: begin
                busy      = 1'b1;
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = (r_pend_valid && (r_pend_addr == r_clr_addr)) ? r_pend_data : '0;
            end
            default: begin
                busy = 1'b1;
            end
        endcase
    end

    // State register and clearing sweep.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= clr_last ? '0 : r_clr_addr + AW'(1);
            end
        end
    end

    // First stage: capture the accepted corner while the memory is read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1.new_mesh <= i_new_mesh;
            r_s1.in_range <= in_range_in;
            r_s1.back     <= back_in;
            r_s1.vidx     <= i_vertex_index;
            r_s1.s        <= i_tex_s;
            r_s1.t        <= i_tex_t;
            r_s1_addr     <= slot_in;
        end
    end

    // Forwarding of the write that coincides with the next corner's read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fw_valid <= 1'b0;
        end else begin
            r_fw_valid <= ram_we && (r_state == ST_RUN);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fw_addr <= ram_waddr;
        r_fw_data <= ram_wdata;
    end

    // Mesh epoch and vertex counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_epoch <= EPOCH_FIRST;
            r_count <= '0;
        end else begin
            if ((r_state == ST_CLEAR) && clr_last) begin
                r_epoch <= EPOCH_FIRST;
            end else if (r_s1_valid) begin
                r_epoch <= epoch_eff;
            end
            if (r_s1_valid) begin
                r_count <= make_new ? cnt_base + CNT_W'(1) : cnt_base;
            end
        end
    end

    // Slot write held back until the clearing pass reaches it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (r_s1_valid && wrap) begin
            r_pend_valid <= make_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && wrap) begin
            r_pend_addr <= r_s1_addr;
            r_pend_data <= new_slot;
        end
    end

    // Result beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            if (!r_s1.in_range) begin
                r_out_index <= '0;
            end else if (make_new) begin
                r_out_index <= cnt_base[OIDX_W-1:0];
            end else begin
                r_out_index <= rd.idx;
            end
            r_out_new <= make_new;
            r_out_src <= make_new ? r_s1.vidx : '0;
            r_out_s   <= make_new ? new_s : '0;
            r_out_t   <= make_new ? r_s1.t : '0;
        end
    end

    assign o_result_valid     = r_out_valid;
    assign o_out_index        = r_out_index;
    assign o_is_new_vertex    = r_out_new;
    assign o_new_source_index = r_out_src;
    assign o_new_s            = r_out_s;
    assign o_new_t            = r_out_t;

    // Configuration register port.
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skin <= '0;
        end else if (cfg_wr && (reg_idx == REG_SKIN_WIDTH)) begin
            r_skin <= pwdata[SKIN_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_SKIN_WIDTH: prdata = {{(APB_DW - SKIN_W){1'b0}}, r_skin};
            default:        prdata = '0;
        endcase
    end

    // Checks on the block's own bookkeeping.
    a_new_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_is_new_vertex |-> (o_out_index + OIDX_W'(1)) == r_count[OIDX_W-1:0])
        else $error("new vertex index does not match the vertex counter");

    a_reuse_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_is_new_vertex |->
            (o_new_source_index == '0) && (o_new_s == '0) && (o_new_t == '0))
        else $error("reused slot result carries vertex fields");

    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !r_s1_valid && busy)
        else $error("corner in flight during the clearing pass");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("epoch mark reached the cleared value");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_result_valid)
        else $error("accepted corner produced no result beat");

endmodule
